>>> sv/palette_colour_cycler_defines.svh
// assertion macros used by the palette colour cycler controller
`ifndef PALETTE_COLOUR_CYCLER_DEFINES_SVH
`define PALETTE_COLOUR_CYCLER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PCC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PCC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pcc_pkg.sv
// shared types and constants of the palette colour cycler
package pcc_pkg;

   localparam int PALETTE_DEPTH  = 4;
   localparam int FRAC_BITS      = 16;
   localparam int CHANNEL_BITS   = 8;
   localparam int NUM_CHANNELS   = 4;
   localparam int COLOUR_BITS    = NUM_CHANNELS * CHANNEL_BITS;
   localparam int PAIR_BITS      = 2 * COLOUR_BITS;
   localparam int COUNT_BITS     = 3;
   localparam int ENTRY_BITS     = $clog2(PALETTE_DEPTH);
   localparam int PHASE_BITS     = ENTRY_BITS + FRAC_BITS;
   localparam int CHAN_SEL_BITS  = $clog2(NUM_CHANNELS);

   localparam int SPEED_BITS     = 24;
   localparam int SPEED_FRAC     = 16;
   localparam int MULT_BITS      = 16;
   localparam int MULT_FRAC      = 8;
   localparam int START_BITS     = 16;
   localparam int ELAPSED_BITS   = 16;

   localparam int RATE_PROD_BITS = SPEED_BITS + MULT_BITS;
   localparam int RATE_SHIFT     = SPEED_FRAC + MULT_FRAC - FRAC_BITS;
   localparam int RATE_BITS      = RATE_PROD_BITS - 1 - RATE_SHIFT;
   localparam int STEP_BITS      = ELAPSED_BITS + RATE_BITS;
   localparam int SUM_BITS       = STEP_BITS + 1;
   localparam int DIV_BITS       = SUM_BITS - FRAC_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_BITS);

   localparam logic [MULT_BITS-1:0] MULT_ONE = MULT_BITS'(1 << MULT_FRAC);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COUNT,
      CSR_PAIR0,
      CSR_PAIR1,
      CSR_SPEED,
      CSR_MULT,
      CSR_START
   } csr_index_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE,
      ST_STEP,
      ST_ADD,
      ST_DIV,
      ST_WRAP,
      ST_LERP,
      ST_LOAD
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic                     capture;
      logic                     rate_en;
      logic                     step_en;
      logic                     add_en;
      logic                     div_en;
      logic                     wrap_en;
      logic                     lerp_en;
      logic [CHAN_SEL_BITS-1:0] ch_sel;
      logic                     load_out;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic restart;
   } status_type;

endpackage

>>> sv/pcc_ctrl.sv
// controller state machine of the palette colour cycler
`include "palette_colour_cycler_defines.svh"

module pcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pcc_pkg::status_type status,
   output pcc_pkg::cmd_type    cmd
);
   import pcc_pkg::*;

   state_type                state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]  div_cnt_ff, div_cnt_in;
   logic [CHAN_SEL_BITS-1:0] ch_cnt_ff, ch_cnt_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     accept;
   logic                     div_last;
   logic                     ch_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign div_last  = (div_cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1));
   assign ch_last   = (ch_cnt_ff == CHAN_SEL_BITS'(NUM_CHANNELS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_RATE;
         ST_RATE: state_in = status.restart ? ST_LERP : ST_STEP;
         ST_STEP: state_in = ST_ADD;
         ST_ADD:  state_in = ST_DIV;
         ST_DIV:  if (div_last) state_in = ST_WRAP;
         ST_WRAP: state_in = ST_LERP;
         ST_LERP: if (ch_last) state_in = ST_LOAD;
         ST_LOAD: if (!out_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd        = '0;
      cmd.ch_sel = ch_cnt_ff;
      case (state_ff)
         ST_IDLE: cmd.capture  = req_valid;
         ST_RATE: cmd.rate_en  = 1'b1;
         ST_STEP: cmd.step_en  = 1'b1;
         ST_ADD:  cmd.add_en   = 1'b1;
         ST_DIV:  cmd.div_en   = 1'b1;
         ST_WRAP: cmd.wrap_en  = 1'b1;
         ST_LERP: cmd.lerp_en  = 1'b1;
         ST_LOAD: cmd.load_out = !out_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
   end

   // step counters and output word flag
   always_comb begin
      div_cnt_in   = (state_ff == ST_DIV) ? div_cnt_ff + 1'b1 : '0;
      ch_cnt_in    = (state_ff == ST_LERP) ? ch_cnt_ff + 1'b1 : '0;
      out_valid_in = cmd.load_out || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         ch_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         ch_cnt_ff    <= ch_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `PCC_ASSERT_NXT(a_accept_starts, accept, state_ff == ST_RATE, "accepted word did not start work")
   `PCC_ASSERT_IMP(a_no_overwrite, cmd.load_out, !rsp_valid || !rsp_stall, "pending result overwritten")
   `PCC_ASSERT_NXT(a_load_shows, cmd.load_out, rsp_valid && state_ff == ST_IDLE, "loaded result not shown")
   `PCC_ASSERT_IMP(a_div_cnt_idle, state_ff != ST_DIV, div_cnt_ff == '0, "divide counter not cleared")

endmodule

>>> sv/pcc_datapath.sv
// datapath of the palette colour cycler: registers, multipliers, serial modulo, blend
module pcc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pcc_pkg::cmd_type                        cmd,
   output pcc_pkg::status_type                     status,
   input  logic                                    req_mode,
   input  logic [pcc_pkg::ELAPSED_BITS-1:0]        req_elapsed_ms,
   input  logic                                    csr_we,
   input  logic [pcc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [pcc_pkg::CSR_DATA_BITS-1:0]       csr_data,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]        rsp_red,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]        rsp_green,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]        rsp_blue,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]        rsp_alpha,
   output logic [pcc_pkg::PHASE_BITS-1:0]          rsp_phase
);
   import pcc_pkg::*;

   // configuration
   logic [COUNT_BITS-1:0]        count_ff;
   logic [PAIR_BITS-1:0]         pair0_ff;
   logic [PAIR_BITS-1:0]         pair1_ff;
   logic signed [SPEED_BITS-1:0] speed_ff;
   logic signed [MULT_BITS-1:0]  mult_ff;
   logic [START_BITS-1:0]        start_ff;

   // working registers
   logic                         mode_ff;
   logic [ELAPSED_BITS-1:0]      elapsed_ff;
   logic [RATE_BITS-1:0]         rate_ff, rate_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic [DIV_BITS-1:0]          div_ff;
   logic [FRAC_BITS-1:0]         low_ff;
   logic [ENTRY_BITS-1:0]        rem_ff, rem_in;
   logic [PHASE_BITS-1:0]        pos_ff;
   logic [CHANNEL_BITS-1:0]      chan_ff [NUM_CHANNELS];

   logic [COUNT_BITS-1:0]            count_act;
   logic signed [MULT_BITS-1:0]      mult_eff;
   logic signed [RATE_PROD_BITS-1:0] rate_prod;
   logic [PHASE_BITS-1:0]            restart_pos;
   logic [SUM_BITS-1:0]              sum;
   logic [ENTRY_BITS:0]              trial;
   logic [ENTRY_BITS-1:0]            from_idx, to_idx;
   logic [COUNT_BITS-1:0]            from_next;
   logic [COLOUR_BITS-1:0]           colour_a, colour_b;
   logic [CHANNEL_BITS-1:0]          chan_a, chan_b;
   logic signed [CHANNEL_BITS:0]     diff;
   logic signed [FRAC_BITS:0]        weight;
   logic signed [CHANNEL_BITS+FRAC_BITS+1:0] blend_prod;
   logic signed [CHANNEL_BITS+1:0]   adjust;
   logic [CHANNEL_BITS+1:0]          blend;

   assign status.restart = mode_ff;

   // palette count in use: zero counts as one, saturates at the depth
   always_comb begin
      if (count_ff == '0)
         count_act = COUNT_BITS'(1);
      else if (count_ff > COUNT_BITS'(PALETTE_DEPTH))
         count_act = COUNT_BITS'(PALETTE_DEPTH);
      else
         count_act = count_ff;
   end

   // rate in phase units per ms, negative or zero gives no motion
   assign mult_eff  = (mult_ff == '0) ? signed'(MULT_ONE) : mult_ff;
   assign rate_prod = speed_ff * mult_eff;
   assign rate_in   = (rate_prod > 0) ? rate_prod[RATE_SHIFT +: RATE_BITS] : '0;
   assign restart_pos = PHASE_BITS'(start_ff) * PHASE_BITS'(count_act);

   // step and phase sum
   assign step_in = STEP_BITS'(elapsed_ff) * STEP_BITS'(rate_ff);
   assign sum     = SUM_BITS'(step_ff) + SUM_BITS'(pos_ff);

   // one quotient bit of the entry-count modulo
   always_comb begin
      trial = {rem_ff, div_ff[DIV_BITS-1]};
      if (trial >= count_act)
         trial = trial - count_act;
      rem_in = trial[ENTRY_BITS-1:0];
   end

   // blend one channel: a + floor((b - a) * w / 2^F)
   always_comb begin
      from_idx  = pos_ff[PHASE_BITS-1 -: ENTRY_BITS];
      from_next = COUNT_BITS'(from_idx) + 1'b1;
      to_idx    = (from_next >= count_act) ? '0 : from_next[ENTRY_BITS-1:0];
      colour_a  = from_idx[1] ? (from_idx[0] ? pair1_ff[PAIR_BITS-1 -: COLOUR_BITS]
                                             : pair1_ff[COLOUR_BITS-1:0])
                              : (from_idx[0] ? pair0_ff[PAIR_BITS-1 -: COLOUR_BITS]
                                             : pair0_ff[COLOUR_BITS-1:0]);
      colour_b  = to_idx[1] ? (to_idx[0] ? pair1_ff[PAIR_BITS-1 -: COLOUR_BITS]
                                         : pair1_ff[COLOUR_BITS-1:0])
                            : (to_idx[0] ? pair0_ff[PAIR_BITS-1 -: COLOUR_BITS]
                                         : pair0_ff[COLOUR_BITS-1:0]);
      chan_a     = colour_a[cmd.ch_sel*CHANNEL_BITS +: CHANNEL_BITS];
      chan_b     = colour_b[cmd.ch_sel*CHANNEL_BITS +: CHANNEL_BITS];
      diff       = signed'({1'b0, chan_b}) - signed'({1'b0, chan_a});
      weight     = signed'({1'b0, pos_ff[FRAC_BITS-1:0]});
      blend_prod = diff * weight;
      adjust     = blend_prod[CHANNEL_BITS+FRAC_BITS+1 -: CHANNEL_BITS+2];
      blend      = (CHANNEL_BITS+2)'(chan_a) + unsigned'(adjust);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_BITS'(1);
         pair0_ff <= '0;
         pair1_ff <= '0;
         speed_ff <= '0;
         mult_ff  <= signed'(MULT_ONE);
         start_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT: count_ff <= csr_data[COUNT_BITS-1:0];
            CSR_PAIR0: pair0_ff <= csr_data[PAIR_BITS-1:0];
            CSR_PAIR1: pair1_ff <= csr_data[PAIR_BITS-1:0];
            CSR_SPEED: speed_ff <= signed'(csr_data[SPEED_BITS-1:0]);
            CSR_MULT:  mult_ff  <= signed'(csr_data[MULT_BITS-1:0]);
            CSR_START: start_ff <= csr_data[START_BITS-1:0];
            default:   ;
         endcase
      end
   end

   // phase accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.rate_en && mode_ff) begin
         pos_ff <= restart_pos;
      end else if (cmd.wrap_en) begin
         pos_ff <= {rem_ff, low_ff};
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_mode;
         elapsed_ff <= req_elapsed_ms;
      end
      if (cmd.rate_en) rate_ff <= rate_in;
      if (cmd.step_en) step_ff <= step_in;
      if (cmd.add_en) begin
         div_ff <= sum[SUM_BITS-1 -: DIV_BITS];
         low_ff <= sum[FRAC_BITS-1:0];
         rem_ff <= '0;
      end else if (cmd.div_en) begin
         div_ff <= {div_ff[DIV_BITS-2:0], 1'b0};
         rem_ff <= rem_in;
      end
      if (cmd.lerp_en) chan_ff[cmd.ch_sel] <= blend[CHANNEL_BITS-1:0];
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_red   <= chan_ff[0];
         rsp_green <= chan_ff[1];
         rsp_blue  <= chan_ff[2];
         rsp_alpha <= chan_ff[3];
         rsp_phase <= pos_ff;
      end
   end

endmodule

>>> sv/palette_colour_cycler.sv
// Palette colour cycler: one phase accumulator over up to four RGBA colours. A tick word
// (mode 0) advances the phase by elapsed_ms times the positive part of speed times
// multiplier and wraps it by the palette count; a restart word (mode 1) sets it to
// start_phase times the count. Each word returns the colour blended between the current
// entry and the next, plus the new phase. One word at a time: a tick runs the 32-step
// serial modulo by the palette count before the four-step channel blend; a restart goes
// directly to the four-step channel blend. A finished result waits in an output
// register, so the next word is worked on while it is stalled. Configuration is taken in
// any cycle (csr_ready is always high) and is to be written only while the block is idle.
module palette_colour_cycler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [pcc_pkg::ELAPSED_BITS-1:0]    req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]    rsp_red,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]    rsp_green,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]    rsp_blue,
   output logic [pcc_pkg::CHANNEL_BITS-1:0]    rsp_alpha,
   output logic [pcc_pkg::PHASE_BITS-1:0]      rsp_phase,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pcc_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import pcc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_we;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // sequencing
   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   pcc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_elapsed_ms (req_elapsed_ms),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_phase      (rsp_phase)
   );

endmodule
